// ----- src/lmfire_pkg.sv -----
// ----------------------------------------------------------------------------
// lmfire_pkg
// Shared sizes, types and the heat-to-color palette of the LED fire effect.
// ----------------------------------------------------------------------------
package lmfire_pkg;

  // Matrix bounds
  localparam int MAX_WIDTH  = 32;
  localparam int MAX_HEIGHT = 32;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WID_W  = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W  = $clog2(MAX_HEIGHT + 1);
  localparam int CELLS  = MAX_WIDTH * MAX_HEIGHT;
  localparam int IDX_W  = $clog2(CELLS);

  // Fixed field widths
  localparam int CFG_W        = 6;
  localparam int HEAT_W       = 8;
  localparam int RAND_W       = 4;
  localparam int CELL_INDEX_W = 10;
  localparam int IN_DATA_W    = 24;
  localparam int OUT_DATA_W   = 40;
  localparam int APB_ADDR_W   = 3;
  localparam int APB_DATA_W   = 32;

  // Register map (index taken from paddr[2])
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  typedef logic [HEAT_W-1:0] heat_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Three-band palette: black to red, red to yellow, yellow to white
  function automatic rgb_t heat_palette(input heat_t t);
    rgb_t  c;
    heat_t d;
    begin
      if (t < 8'd85) begin
        c.red   = 8'(t * 2'd3);
        c.green = 8'd0;
        c.blue  = 8'd0;
      end else if (t < 8'd170) begin
        d       = t - 8'd85;
        c.red   = 8'hFF;
        c.green = 8'(d * 2'd3);
        c.blue  = 8'd0;
      end else begin
        d       = t - 8'd170;
        c.red   = 8'hFF;
        c.green = 8'hFF;
        c.blue  = 8'(d * 2'd3);
      end
      return c;
    end
  endfunction

endpackage

// ----- src/led_matrix_fire_effect_top.sv -----
// ----------------------------------------------------------------------------
// led_matrix_fire_effect_top
// Fire effect over a heat map, one cell per word in raster order.
// ----------------------------------------------------------------------------
// After reset the block clears every heat-map entry of the heat memory and
// holds in_tready low; configuration writes are taken meanwhile. Then it
// takes one cell per clock while the result stream is not stalled: each
// input word is one cell, row 0 at the bottom, columns left to right. A
// cell's result word passes the heat memory read register, then cool/
// propagate/palette into the output register. The single read port of the
// heat memory and the column-wide line memory set that one-cell-per-clock
// rate; back-to-back cells hitting the same entry are served by forwarding.
// Writing grid_width or grid_height restarts the frame at row 0, column 0;
// the heat map is kept. Write registers only while no cell is in flight.
// ----------------------------------------------------------------------------
module led_matrix_fire_effect_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [3:0] cool_rand, [11:4] spark_roll, [19:12] spark_heat, [23:20] zero
  input  logic [lmfire_pkg::IN_DATA_W-1:0]     in_tdata,
  // result stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [9:0] cell_index, [17:10] red, [25:18] green, [33:26] blue, [39:34] zero
  output logic [lmfire_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                                 out_tlast,
  // configuration port
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [lmfire_pkg::APB_ADDR_W-1:0]    cfg_paddr,
  input  logic [lmfire_pkg::APB_DATA_W-1:0]    cfg_pwdata,
  output logic [lmfire_pkg::APB_DATA_W-1:0]    cfg_prdata,
  output logic                                 cfg_pready
);
  import lmfire_pkg::*;

  localparam logic [HEAT_W-1:0] COOL_LIMIT = 8'd20;
  localparam logic [HEAT_W-1:0] COOL_BASE  = 8'd5;
  localparam logic [HEAT_W-1:0] SPARK_ROLL = 8'd150;
  localparam logic [HEAT_W-1:0] SPARK_BASE = 8'd180;
  localparam logic [HEAT_W-1:0] SPARK_MASK = 8'd75;
  // floor(x/3) = (x * 683) >> 11 for x below 2048
  localparam logic [10:0]       DIV3_MUL   = 11'd683;
  localparam int                DIV3_SHIFT = 11;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0] grid_width_r;
  logic [CFG_W-1:0] grid_height_r;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= CFG_W'(32);
      grid_height_r <= CFG_W'(32);
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_GRID_WIDTH:  grid_width_r  <= cfg_pwdata[CFG_W-1:0];
        REG_GRID_HEIGHT: grid_height_r <= cfg_pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_GRID_WIDTH:  cfg_prdata = APB_DATA_W'(grid_width_r);
      REG_GRID_HEIGHT: cfg_prdata = APB_DATA_W'(grid_height_r);
      default:         cfg_prdata = '0;
    endcase
  end

  // Zero or oversize means the maximum
  logic [WID_W-1:0] eff_w;
  logic [HGT_W-1:0] eff_h;

  always_comb begin
    if (grid_width_r == '0 || 32'(grid_width_r) > MAX_WIDTH) eff_w = WID_W'(MAX_WIDTH);
    else                                                     eff_w = WID_W'(grid_width_r);
    if (grid_height_r == '0 || 32'(grid_height_r) > MAX_HEIGHT) eff_h = HGT_W'(MAX_HEIGHT);
    else                                                        eff_h = HGT_W'(grid_height_r);
  end

  // --------------------------------------------------------------------------
  // Heat memory clearing pass after reset
  // --------------------------------------------------------------------------
  logic             clr_busy_r;
  logic [IDX_W-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == IDX_W'(CELLS - 1)) clr_busy_r <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Handshake and pipeline control
  // --------------------------------------------------------------------------
  logic s1_valid_r;
  logic out_valid_r;
  logic s1_adv;
  logic in_acc;

  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !clr_busy_r && (!s1_valid_r || s1_adv);
  assign in_acc    = in_tvalid && in_tready;

  // --------------------------------------------------------------------------
  // Raster position and cell address
  // --------------------------------------------------------------------------
  logic [COL_W-1:0] col_r, col_nxt, cur_col;
  logic [ROW_W-1:0] row_r, row_nxt, cur_row;
  logic [IDX_W-1:0] cur_idx;
  logic             cur_last;
  logic             col_end;
  logic             row_end;

  always_comb begin
    cur_col = col_r;
    cur_row = row_r;
    if (col_r >= eff_w || row_r >= eff_h) begin
      cur_col = '0;
      cur_row = '0;
    end
    cur_idx  = IDX_W'(cur_row) * IDX_W'(eff_w) + IDX_W'(cur_col);
    col_end  = (WID_W'(cur_col) + 1'b1) == eff_w;
    row_end  = (HGT_W'(cur_row) + 1'b1) == eff_h;
    cur_last = col_end && row_end;
    if (!col_end) begin
      col_nxt = cur_col + 1'b1;
      row_nxt = cur_row;
    end else begin
      col_nxt = '0;
      row_nxt = row_end ? '0 : cur_row + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1 registers: cell info alongside the memory reads
  // --------------------------------------------------------------------------
  logic [IDX_W-1:0]  s1_idx_r;
  logic [COL_W-1:0]  s1_col_r;
  logic              s1_row0_r;
  logic              s1_rowge2_r;
  logic              s1_last_r;
  logic [RAND_W-1:0] s1_rnd_r;
  logic              s1_ignite_r;
  logic [HEAT_W-1:0] s1_spark_r;
  logic              hfwd_r;
  heat_t             hfwd_data_r;
  logic              lfwd_r;
  logic [2*HEAT_W-1:0] lfwd_data_r;

  heat_t             heat_rd_r;
  logic [2*HEAT_W-1:0] line_rd_r;

  // Stage 1 datapath results
  heat_t               s1_t;
  heat_t               s1_cooled;
  logic [2*HEAT_W-1:0] s1_line_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_idx_r    <= cur_idx;
      s1_col_r    <= cur_col;
      s1_row0_r   <= (cur_row == '0);
      s1_rowge2_r <= (32'(cur_row) >= 2);
      s1_last_r   <= cur_last;
      s1_rnd_r    <= in_tdata[3:0];
      s1_ignite_r <= in_tdata[11:4] < SPARK_ROLL;
      s1_spark_r  <= in_tdata[19:12] & SPARK_MASK;
      // the item in stage 1 writes back at this same edge
      hfwd_r      <= s1_valid_r && (s1_idx_r == cur_idx);
      hfwd_data_r <= s1_t;
      lfwd_r      <= s1_valid_r && (s1_col_r == cur_col);
      lfwd_data_r <= s1_line_wdata;
    end
  end

  // --------------------------------------------------------------------------
  // Memories: heat map and per-column cooled history {two below, below}
  // --------------------------------------------------------------------------
  heat_t               heat_mem [CELLS];
  logic [2*HEAT_W-1:0] line_mem [MAX_WIDTH];

  logic             s1_wr;
  logic             heat_we;
  logic [IDX_W-1:0] heat_waddr;
  heat_t            heat_wdata;

  assign s1_wr      = s1_valid_r && s1_adv;
  assign heat_we    = clr_busy_r || s1_wr;
  assign heat_waddr = clr_busy_r ? clr_addr_r : s1_idx_r;
  assign heat_wdata = clr_busy_r ? '0 : s1_t;

  always_ff @(posedge clk) begin
    if (heat_we) heat_mem[heat_waddr] <= heat_wdata;
    if (in_acc)  heat_rd_r <= heat_mem[cur_idx];
  end

  always_ff @(posedge clk) begin
    if (s1_wr)  line_mem[s1_col_r] <= s1_line_wdata;
    if (in_acc) line_rd_r <= line_mem[cur_col];
  end

  // --------------------------------------------------------------------------
  // Cool, propagate upward, ignite
  // --------------------------------------------------------------------------
  heat_t       heat_cur;
  heat_t       below;
  heat_t       two_below;
  logic [9:0]  div_num;
  logic [20:0] div_prod;

  always_comb begin
    heat_cur  = hfwd_r ? hfwd_data_r : heat_rd_r;
    below     = lfwd_r ? lfwd_data_r[HEAT_W-1:0] : line_rd_r[HEAT_W-1:0];
    two_below = lfwd_r ? lfwd_data_r[2*HEAT_W-1:HEAT_W] : line_rd_r[2*HEAT_W-1:HEAT_W];

    if (heat_cur > COOL_LIMIT) s1_cooled = heat_cur - HEAT_W'(s1_rnd_r) - COOL_BASE;
    else                       s1_cooled = '0;

    div_num  = 10'(below) + {1'b0, two_below, 1'b0};
    div_prod = 21'(div_num) * 21'(DIV3_MUL);

    if (s1_rowge2_r)                    s1_t = div_prod[DIV3_SHIFT +: HEAT_W];
    else if (s1_row0_r && s1_ignite_r)  s1_t = SPARK_BASE + s1_spark_r;
    else                                s1_t = s1_cooled;

    s1_line_wdata = {below, s1_cooled};
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic [CELL_INDEX_W-1:0] out_idx_r;
  rgb_t                    out_rgb_r;
  logic                    out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_wr) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_wr) begin
      out_idx_r  <= CELL_INDEX_W'(s1_idx_r);
      out_rgb_r  <= heat_palette(s1_t);
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {6'd0, out_rgb_r.blue, out_rgb_r.green, out_rgb_r.red, out_idx_r};

endmodule
